// ===== sv/control_flow_termination_check_defines.svh =====
// Assertion macros shared by the termination check RTL.
`ifndef CONTROL_FLOW_TERMINATION_CHECK_DEFINES_SVH
`define CONTROL_FLOW_TERMINATION_CHECK_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CTFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ctfc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CTFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ctfc assertion failed");

`endif

// ===== sv/ctfc_pkg.sv =====
// Types, constants and microcode table of the control-flow termination check.
package ctfc_pkg;

   localparam int MAX_INSTR_DEF = 1024;
   localparam int KIND_W        = 2;
   localparam int TARGET_W      = 11;
   localparam int VERDICT_W     = 2;
   localparam int STEP_W        = 4;

   localparam logic [KIND_W-1:0] KIND_FALL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_JUMP  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

   localparam logic [VERDICT_W-1:0] VERDICT_NEVER     = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_SOMETIMES = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_ALWAYS    = 2'd2;

   // Node marks: bit 1 visited, bit 0 on the walk stack.
   localparam logic [1:0] NODE_CLEAR = 2'b00;
   localparam logic [1:0] NODE_DONE  = 2'b10;
   localparam logic [1:0] NODE_OPEN  = 2'b11;

   localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_CLEAR   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_INIT    = 4'd2;
   localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_EDGE    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_PUSH    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_POP     = 4'd7;
   localparam logic [STEP_W-1:0] STEP_RESTORE = 4'd8;
   localparam logic [STEP_W-1:0] STEP_DONE    = 4'd9;

   typedef enum logic [3:0] {
      ACT_IDLE,
      ACT_CLEAR,
      ACT_INIT,
      ACT_FETCH,
      ACT_EDGE,
      ACT_CHECK,
      ACT_PUSH,
      ACT_POP,
      ACT_RESTORE,
      ACT_DONE
   } act_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_START,
      COND_CLR_MORE,
      COND_NO_EDGE,
      COND_VISITED,
      COND_LAST_ENTRY
   } cond_type;

   typedef struct packed {
      act_type             act;
      cond_type            cond;
      logic [STEP_W-1:0]   jump;
   } ucode_type;

   // Control store: jump when the condition holds, else advance one step.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type uc;
      unique case (step)
         STEP_IDLE:    uc = '{act: ACT_IDLE,    cond: COND_NO_START,   jump: STEP_IDLE};
         STEP_CLEAR:   uc = '{act: ACT_CLEAR,   cond: COND_CLR_MORE,   jump: STEP_CLEAR};
         STEP_INIT:    uc = '{act: ACT_INIT,    cond: COND_NONE,       jump: STEP_IDLE};
         STEP_FETCH:   uc = '{act: ACT_FETCH,   cond: COND_NONE,       jump: STEP_IDLE};
         STEP_EDGE:    uc = '{act: ACT_EDGE,    cond: COND_NO_EDGE,    jump: STEP_POP};
         STEP_CHECK:   uc = '{act: ACT_CHECK,   cond: COND_VISITED,    jump: STEP_EDGE};
         STEP_PUSH:    uc = '{act: ACT_PUSH,    cond: COND_ALWAYS,     jump: STEP_FETCH};
         STEP_POP:     uc = '{act: ACT_POP,     cond: COND_LAST_ENTRY, jump: STEP_DONE};
         STEP_RESTORE: uc = '{act: ACT_RESTORE, cond: COND_ALWAYS,     jump: STEP_FETCH};
         STEP_DONE:    uc = '{act: ACT_DONE,    cond: COND_ALWAYS,     jump: STEP_IDLE};
         default:      uc = '{act: ACT_IDLE,    cond: COND_ALWAYS,     jump: STEP_IDLE};
      endcase
      return uc;
   endfunction

endpackage

// ===== sv/ctfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ctfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/control_flow_termination_check.sv =====
// Control-flow termination check: loads a program, walks its successor graph, gives a verdict.
// Instructions are taken while idle and the verdict output is free; the last one starts a walk
// that clears the n + 1 node marks, seeds node 0, then fetches, checks and pushes each further
// reached node, checks other edges and pops to finish, paced by the registered program, mark and
// stack reads. The verdict register then frees the input; empty markers answer from idle.
// Reset (synchronous, active high) clears step counter, count, end and cycle flags, rsp valid.
`include "control_flow_termination_check_defines.svh"
module control_flow_termination_check
   import ctfc_pkg::*;
#(
   parameter int MAX_INSTR = MAX_INSTR_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_instr_kind,
   input  logic [TARGET_W-1:0]  req_jump_target,
   input  logic                 req_last_instr,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [VERDICT_W-1:0] rsp_verdict
);

   localparam int NW  = $clog2(MAX_INSTR + 1);
   localparam int PAW = (MAX_INSTR > 1) ? $clog2(MAX_INSTR) : 1;
   localparam int SPW = $clog2(MAX_INSTR + 2);
   localparam int EW  = (NW > TARGET_W) ? NW : TARGET_W;
   localparam int PW  = KIND_W + TARGET_W;
   localparam int SW  = NW + 2;

   // sequencer
   logic [STEP_W-1:0] upc_ff, upc_in;
   ucode_type         uc;
   logic              cond_hit;

   // walk registers
   logic [NW-1:0]  count_ff, count_in;
   logic [NW-1:0]  clr_ptr_ff, clr_ptr_in;
   logic [NW-1:0]  v_ff, v_in;
   logic [1:0]     k_ff, k_in;
   logic [NW-1:0]  w_ff, w_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic           end_ff, end_in;
   logic           cycle_ff, cycle_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;

   // memory ports
   logic            prog_we, prog_re;
   logic [PAW-1:0]  prog_waddr, prog_raddr;
   logic [PW-1:0]   prog_wdata, prog_rdata;
   logic            mark_we, mark_re;
   logic [NW-1:0]   mark_waddr, mark_raddr;
   logic [1:0]      mark_wdata, mark_rdata;
   logic            stk_we, stk_re;
   logic [NW-1:0]   stk_waddr, stk_raddr;
   logic [SW-1:0]   stk_wdata, stk_rdata;

   // edge decode
   logic [KIND_W-1:0]   cur_kind;
   logic [TARGET_W-1:0] cur_tgt;
   logic [EW-1:0]       tgt_node, end_node, tgt_clamp;
   logic [NW-1:0]       dest;
   logic [1:0]          edge_cnt;
   logic                no_edge;
   logic                req_fire;
   logic                walk_start;

   ctfc_ram #(.WIDTH(PW), .DEPTH(MAX_INSTR)) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (prog_waddr),
      .wr_data (prog_wdata),
      .rd_en   (prog_re),
      .rd_addr (prog_raddr),
      .rd_data (prog_rdata)
   );

   ctfc_ram #(.WIDTH(2), .DEPTH(MAX_INSTR + 1)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_en   (mark_re),
      .rd_addr (mark_raddr),
      .rd_data (mark_rdata)
   );

   ctfc_ram #(.WIDTH(SW), .DEPTH(MAX_INSTR + 1)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign uc        = ucode_rom(upc_ff);
   assign req_ready = (uc.act == ACT_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign walk_start = req_fire && req_last_instr && (req_instr_kind != KIND_EMPTY);

   // successor of the top node for its next untaken edge
   always_comb begin
      cur_kind  = prog_rdata[PW-1:TARGET_W];
      cur_tgt   = prog_rdata[TARGET_W-1:0];
      end_node  = EW'(count_ff);
      tgt_node  = (cur_tgt == '0) ? '0 : (EW'(cur_tgt) - EW'(1));
      tgt_clamp = (tgt_node > end_node) ? end_node : tgt_node;
      if (cur_kind == KIND_FALL || (cur_kind == KIND_COND && k_ff == 2'd1)) begin
         dest = v_ff + NW'(1);
      end else begin
         dest = tgt_clamp[NW-1:0];
      end
      if (v_ff >= count_ff) begin
         edge_cnt = 2'd0;
      end else if (cur_kind == KIND_COND) begin
         edge_cnt = 2'd2;
      end else begin
         edge_cnt = 2'd1;
      end
      no_edge = (k_ff >= edge_cnt);
   end

   always_comb begin
      unique case (uc.cond)
         COND_NONE:       cond_hit = 1'b0;
         COND_ALWAYS:     cond_hit = 1'b1;
         COND_NO_START:   cond_hit = !walk_start;
         COND_CLR_MORE:   cond_hit = (clr_ptr_ff != count_ff);
         COND_NO_EDGE:    cond_hit = no_edge;
         COND_VISITED:    cond_hit = mark_rdata[1];
         COND_LAST_ENTRY: cond_hit = (sp_ff == SPW'(1));
         default:         cond_hit = 1'b1;
      endcase
      upc_in = cond_hit ? uc.jump : (upc_ff + STEP_W'(1));
   end

   always_comb begin
      count_in     = count_ff;
      clr_ptr_in   = clr_ptr_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      sp_in        = sp_ff;
      end_in       = end_ff;
      cycle_in     = cycle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      verdict_in   = verdict_ff;

      prog_we    = 1'b0;
      prog_waddr = count_ff[PAW-1:0];
      prog_wdata = {req_instr_kind, req_jump_target};
      prog_re    = 1'b0;
      prog_raddr = v_ff[PAW-1:0];
      mark_we    = 1'b0;
      mark_waddr = clr_ptr_ff;
      mark_wdata = NODE_CLEAR;
      mark_re    = 1'b0;
      mark_raddr = dest;
      stk_we     = 1'b0;
      stk_waddr  = NW'(sp_ff - SPW'(1));
      stk_wdata  = {v_ff, k_ff};
      stk_re     = 1'b0;
      stk_raddr  = NW'(sp_ff - SPW'(2));

      unique case (uc.act)
         ACT_IDLE: begin
            clr_ptr_in = '0;
            if (req_fire) begin
               if (req_instr_kind == KIND_EMPTY) begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  verdict_in   = VERDICT_NEVER;
               end else if (count_ff < NW'(MAX_INSTR)) begin
                  prog_we  = 1'b1;
                  count_in = count_ff + NW'(1);
               end
            end
         end
         ACT_CLEAR: begin
            mark_we    = 1'b1;
            clr_ptr_in = clr_ptr_ff + NW'(1);
         end
         ACT_INIT: begin
            mark_we    = 1'b1;
            mark_waddr = '0;
            mark_wdata = NODE_OPEN;
            v_in       = '0;
            k_in       = '0;
            sp_in      = SPW'(1);
            end_in     = 1'b0;
            cycle_in   = 1'b0;
         end
         ACT_FETCH: begin
            prog_re = 1'b1;
         end
         ACT_EDGE: begin
            if (!no_edge) begin
               mark_re = 1'b1;
               w_in    = dest;
               k_in    = k_ff + 2'd1;
               if (dest == count_ff) begin
                  end_in = 1'b1;
               end
            end
         end
         ACT_CHECK: begin
            if (mark_rdata[1] && mark_rdata[0]) begin
               cycle_in = 1'b1;
            end
         end
         ACT_PUSH: begin
            // save the top with its taken count, descend into the new node
            mark_we    = 1'b1;
            mark_waddr = w_ff;
            mark_wdata = NODE_OPEN;
            stk_we     = 1'b1;
            v_in       = w_ff;
            k_in       = '0;
            sp_in      = sp_ff + SPW'(1);
         end
         ACT_POP: begin
            mark_we    = 1'b1;
            mark_waddr = v_ff;
            mark_wdata = NODE_DONE;
            stk_re     = (sp_ff != SPW'(1));
            sp_in      = sp_ff - SPW'(1);
         end
         ACT_RESTORE: begin
            v_in = stk_rdata[SW-1:2];
            k_in = stk_rdata[1:0];
         end
         ACT_DONE: begin
            count_in     = '0;
            rsp_valid_in = 1'b1;
            if (!end_ff) begin
               verdict_in = VERDICT_NEVER;
            end else if (cycle_ff) begin
               verdict_in = VERDICT_SOMETIMES;
            end else begin
               verdict_in = VERDICT_ALWAYS;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= STEP_IDLE;
         count_ff     <= '0;
         end_ff       <= 1'b0;
         cycle_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         count_ff     <= count_in;
         end_ff       <= end_in;
         cycle_ff     <= cycle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ptr_ff <= clr_ptr_in;
      v_ff       <= v_in;
      k_ff       <= k_in;
      w_ff       <= w_in;
      sp_ff      <= sp_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   `CTFC_ASSERT_NOW(a_sp_in_range, clock, reset, upc_ff == STEP_EDGE, (sp_ff != '0) && (sp_ff <= SPW'(MAX_INSTR + 1)))
   `CTFC_ASSERT_NOW(a_top_within_graph, clock, reset, upc_ff == STEP_EDGE, v_ff <= count_ff)
   `CTFC_ASSERT_NOW(a_clear_within_graph, clock, reset, upc_ff == STEP_CLEAR, clr_ptr_ff <= count_ff)
   `CTFC_ASSERT_NEXT(a_done_gives_verdict, clock, reset, upc_ff == STEP_DONE, rsp_valid_ff && (rsp_verdict != 2'd3))

endmodule
